[src/order_keeping_duplicate_remover_top_defines.svh]
// Assertion macros shared by the checker of the duplicate remover.
`ifndef ORDER_KEEPING_DUPLICATE_REMOVER_TOP_DEFINES_SVH
`define ORDER_KEEPING_DUPLICATE_REMOVER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define OKDR_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("okdr check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define OKDR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("okdr check failed");

`endif

[src/okdr_pkg.sv]
// Package: word types and controller states of the duplicate remover.
`timescale 1ns / 1ps

package okdr_pkg;

    localparam int ValueW = 32;

    typedef struct packed {
        logic signed [ValueW-1:0] value;
        logic                     last;
    } in_word_t;

    typedef struct packed {
        logic signed [ValueW-1:0] value_out;
        logic                     kept;
        logic                     overflow;
        logic                     last_out;
    } out_word_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } scan_state_t;

endpackage

[src/okdr_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps

module okdr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AddrW-1:0] wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AddrW-1:0] rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[src/okdr_scan.sv]
// Controller: scans the distinct-value store, appends new values, keeps the fill count.
`timescale 1ns / 1ps

module okdr_scan #(
    parameter int MAX_DISTINCT = 32,
    localparam int AddrW = $clog2(MAX_DISTINCT),
    localparam int CntW  = $clog2(MAX_DISTINCT + 1)
) (
    input  logic                    clk,
    input  logic                    rst_n,
    // input channel
    input  logic                    item_valid,
    output logic                    item_ready,
    input  okdr_pkg::in_word_t      item,
    // result toward the output register
    output logic                    res_valid,
    input  logic                    res_ready,
    output okdr_pkg::out_word_t     res,
    // store port
    output logic                    wr_en,
    output logic [AddrW-1:0]        wr_addr,
    output logic [okdr_pkg::ValueW-1:0] wr_data,
    output logic                    rd_en,
    output logic [AddrW-1:0]        rd_addr,
    input  logic [okdr_pkg::ValueW-1:0] rd_data
);

    okdr_pkg::scan_state_t state_reg, state_next;
    logic [CntW-1:0]  count_reg, count_next;
    logic [AddrW-1:0] idx_reg, idx_next;
    logic [okdr_pkg::ValueW-1:0] value_reg, value_next;
    logic last_reg, last_next;
    logic kept_reg, kept_next;
    logic ovf_reg, ovf_next;

    logic accept;
    logic hit;
    logic at_end;
    logic has_room;

    assign item_ready = (state_reg == okdr_pkg::ST_IDLE);
    assign accept     = item_valid && item_ready;

    // rd_data holds entry idx_reg while scanning
    assign hit      = (count_reg != '0) && (rd_data == value_reg);
    assign at_end   = (count_reg == '0) || (CntW'(idx_reg) == count_reg - CntW'(1));
    assign has_room = (count_reg < CntW'(MAX_DISTINCT));

    assign res_valid = (state_reg == okdr_pkg::ST_DONE);
    assign res.value_out = value_reg;
    assign res.kept      = kept_reg;
    assign res.overflow  = ovf_reg;
    assign res.last_out  = last_reg;

    assign wr_addr = count_reg[AddrW-1:0];
    assign wr_data = value_reg;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        value_next = value_reg;
        last_next  = last_reg;
        kept_next  = kept_reg;
        ovf_next   = ovf_reg;
        wr_en      = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = idx_reg + AddrW'(1);
        unique case (state_reg)
            okdr_pkg::ST_IDLE:
            begin
                rd_addr = '0;
                if (accept)
                begin
                    rd_en      = 1'b1;
                    idx_next   = '0;
                    value_next = item.value;
                    last_next  = item.last;
                    state_next = okdr_pkg::ST_SCAN;
                end
            end
            okdr_pkg::ST_SCAN:
            begin
                if (hit)
                begin
                    kept_next  = 1'b0;
                    ovf_next   = 1'b0;
                    state_next = okdr_pkg::ST_DONE;
                end
                else if (at_end)
                begin
                    kept_next  = 1'b1;
                    ovf_next   = !has_room;
                    if (has_room)
                    begin
                        wr_en      = 1'b1;
                        count_next = count_reg + CntW'(1);
                    end
                    state_next = okdr_pkg::ST_DONE;
                end
                else
                begin
                    rd_en    = 1'b1;
                    idx_next = idx_reg + AddrW'(1);
                end
            end
            okdr_pkg::ST_DONE:
            begin
                if (res_ready)
                begin
                    if (last_reg)
                    begin
                        count_next = '0;
                    end
                    state_next = okdr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = okdr_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= okdr_pkg::ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        value_reg <= value_next;
        last_reg  <= last_next;
        kept_reg  <= kept_next;
        ovf_reg   <= ovf_next;
    end

endmodule

[src/okdr_out_reg.sv]
// Output register: holds one result word so the controller can move on.
`timescale 1ns / 1ps

module okdr_out_reg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load_valid,
    output logic                load_ready,
    input  okdr_pkg::out_word_t load_word,
    output logic                result_valid,
    input  logic                result_ready,
    output okdr_pkg::out_word_t result
);

    logic valid_reg, valid_next;
    okdr_pkg::out_word_t word_reg, word_next;

    assign load_ready   = !valid_reg || result_ready;
    assign result_valid = valid_reg;
    assign result       = word_reg;

    always_comb
    begin
        valid_next = valid_reg;
        word_next  = word_reg;
        if (load_valid && load_ready)
        begin
            valid_next = 1'b1;
            word_next  = load_word;
        end
        else if (result_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

endmodule

[src/order_keeping_duplicate_remover_top.sv]
// Top level of the order-keeping duplicate remover.
//
// Input channel item_valid / item_ready / item carries one word per value:
// a signed 32-bit value and a last flag that closes the set. Output channel
// result_valid / result_ready / result returns exactly one word per input:
// the value, kept (first occurrence in this set), overflow (new value but
// the store already holds MAX_DISTINCT entries) and last_out.
// Distinct values live in a single RAM with a registered read.
// The controller streams entries 0..n-1 out of that read port, one per
// cycle, comparing each with the incoming value; a miss with room left
// appends the value at entry n in the same cycle as the final compare.
// Per item the controller steps through the scan state (left early on a
// match), a handoff state and the idle state, and takes no new input until
// it is back in idle. n is the number of distinct values held. Reset
// clears the fill count and state but not the RAM; entries at or above
// the count are never compared, so the RAM needs no clearing pass. A last
// word returns the count to 0.
// A result waits in the output register while the receiver stalls; the
// next input can be taken and scanned meanwhile, and its result is held
// in the controller until the register frees.
`timescale 1ns / 1ps

module order_keeping_duplicate_remover_top #(
    parameter int MAX_DISTINCT = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  okdr_pkg::in_word_t  item,
    output logic                result_valid,
    input  logic                result_ready,
    output okdr_pkg::out_word_t result
);

    localparam int AddrW = $clog2(MAX_DISTINCT);

    logic                        wr_en;
    logic [AddrW-1:0]            wr_addr;
    logic [okdr_pkg::ValueW-1:0] wr_data;
    logic                        rd_en;
    logic [AddrW-1:0]            rd_addr;
    logic [okdr_pkg::ValueW-1:0] rd_data;

    logic                res_valid;
    logic                res_ready;
    okdr_pkg::out_word_t res;

    // distinct-value store
    okdr_ram #(
        .WIDTH (okdr_pkg::ValueW),
        .DEPTH (MAX_DISTINCT)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // scan / append sequencer and fill count
    okdr_scan #(
        .MAX_DISTINCT (MAX_DISTINCT)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data)
    );

    // result register toward the receiver
    okdr_out_reg u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .load_valid   (res_valid),
        .load_ready   (res_ready),
        .load_word    (res),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

[src/okdr_checker.sv]
// Port-level checker for the duplicate remover, bound to the top level.
`timescale 1ns / 1ps
`include "order_keeping_duplicate_remover_top_defines.svh"

module okdr_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                item_valid,
    input logic                item_ready,
    input logic                result_valid,
    input logic                result_ready,
    input okdr_pkg::out_word_t result
);

    // a duplicate never reports overflow
    `OKDR_ASSERT_NOW(a_dup_no_ovf, result_valid && !result.kept, !result.overflow)

    // overflow only on a value that is kept
    `OKDR_ASSERT_NOW(a_ovf_kept, result_valid && result.overflow, result.kept)

    // one word in flight: input closes right after an accept
    `OKDR_ASSERT_NEXT(a_one_in_flight, item_valid && item_ready, !item_ready)

    // a stalled result word holds
    `OKDR_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result))

endmodule

bind order_keeping_duplicate_remover_top okdr_checker u_okdr_checker (.*);
